FILE: design/ipv6ehw_pkg.sv
// Shared types, protocol numbers and phase codes of the IPv6 extension header walker.
package ipv6ehw_pkg;

  // Default limit on walked extension headers.
  localparam int unsigned MAX_HEADERS_DEF = 5;

  // Fixed IPv6 header geometry.
  localparam logic [15:0] FIXED_LEN = 16'd40;
  localparam logic [15:0] NH_POS    = 16'd6;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;
  localparam logic [15:0] FRAG_LEN  = 16'd8;

  // Protocol numbers the walk cares about.
  localparam logic [7:0] P_HOPOPTS  = 8'd0;
  localparam logic [7:0] P_ROUTING  = 8'd43;
  localparam logic [7:0] P_FRAGMENT = 8'd44;
  localparam logic [7:0] P_ESP      = 8'd50;
  localparam logic [7:0] P_AH       = 8'd51;
  localparam logic [7:0] P_NONE     = 8'd59;
  localparam logic [7:0] P_DSTOPTS  = 8'd60;

  // Walk phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIXED = 2'd1;
  localparam logic [1:0] PH_EXT   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BREAK = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] start_offset;
    logic [15:0] l2_length;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] l3_length;
    logic [7:0]  l4_protocol;
    logic [15:0] next_offset;
  } out_beat_t;

  // Per-packet walk state, apart from the extension header count.
  typedef struct packed {
    logic [15:0] byte_pos;
    logic [15:0] nh_pos;
    logic [7:0]  cur_proto;
    logic [7:0]  cap_nh;
    logic [1:0]  phase;
    logic [15:0] base_off;
    logic [15:0] link_len;
  } walk_state_t;

endpackage

FILE: design/ipv6ehw_if.sv
// Valid/ready channel interfaces for the packet byte input and the result output.
interface ipv6ehw_in_if;
  logic                 valid;
  logic                 ready;
  ipv6ehw_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipv6ehw_out_if;
  logic                  valid;
  logic                  ready;
  ipv6ehw_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ipv6_extension_header_walker.sv
// Top level of the IPv6 extension header walker: input register, walk state and result register.
//
// Usage: packet bytes enter one per beat on beat_in_i, starting at the first byte of the
// fixed IPv6 header, which carries first_byte together with start_offset and l2_length.
// The walker skips the fixed 40-byte header, follows hop-by-hop, routing and destination
// options headers and stops at a fragment header or at an upper-layer protocol. Each
// packet yields at most one result beat on beat_out_o: status, L3 length, L4 protocol and
// the offset behind the headers. The result leaves as soon as it is decided; the rest of
// the packet is still consumed but produces nothing. A first_byte in mid packet restarts
// the walk and the old packet gives no result.
//
// Timing: a byte is taken into the input register and evaluated from there by the
// combinational walk logic once the result slot is free. If it decides the packet, its
// result is loaded into the result register at the edge that updates the walk state, and
// leaves from the result register. One byte per cycle is sustained while the receiver
// takes results without stalling.
//
// Reset clears the walk state to idle and empties both registers. When the receiver
// stalls with a result waiting, the result register holds it and the byte in the input
// register waits as well, since it may decide a packet; input ready then drops as soon
// as a byte is waiting in the input register, and rises again when the result is taken.
module ipv6_extension_header_walker #(
  parameter int unsigned MAX_HEADERS = ipv6ehw_pkg::MAX_HEADERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipv6ehw_in_if.sink           beat_in_i,
  ipv6ehw_out_if.source        beat_out_o
);

  localparam int unsigned CntW = $clog2(MAX_HEADERS + 1);

  // Input register.
  logic                   inq_v_q;
  ipv6ehw_pkg::in_beat_t  inq_q;

  // Walk state.
  ipv6ehw_pkg::walk_state_t state_q;
  ipv6ehw_pkg::walk_state_t state_d;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;

  // Result register.
  logic                   outq_v_q;
  ipv6ehw_pkg::out_beat_t outq_q;

  logic                   res_valid;
  ipv6ehw_pkg::out_beat_t res;
  logic                   out_free;
  logic                   proc;
  logic                   in_take;

  // The result slot is free when empty or being read this cycle. The byte in the input
  // register is evaluated only then, since it may produce a result.
  assign out_free = !outq_v_q || beat_out_o.ready;
  assign proc     = inq_v_q && out_free;
  assign in_take  = beat_in_i.valid && beat_in_i.ready;

  assign beat_in_i.ready  = !inq_v_q || out_free;
  assign beat_out_o.valid = outq_v_q;
  assign beat_out_o.data  = outq_q;

  ipv6ehw_step #(
    .MAX_HEADERS (MAX_HEADERS)
  ) u_step (
    .state_i     (state_q),
    .count_i     (count_q),
    .beat_i      (inq_q),
    .state_o     (state_d),
    .count_o     (count_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_v_q  <= 1'b0;
      outq_v_q <= 1'b0;
      state_q  <= '{phase: ipv6ehw_pkg::PH_IDLE, default: '0};
      count_q  <= '0;
    end else begin
      if (in_take) begin
        inq_v_q <= 1'b1;
      end else if (proc) begin
        inq_v_q <= 1'b0;
      end

      if (proc) begin
        state_q <= state_d;
        count_q <= count_d;
      end

      if (proc && res_valid) begin
        outq_v_q <= 1'b1;
      end else if (beat_out_o.ready) begin
        outq_v_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      inq_q <= beat_in_i.data;
    end
    if (proc && res_valid) begin
      outq_q <= res;
    end
  end

  // The walk count never passes the header limit.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_HEADERS))
    else $error("extension header count above limit");

  // While the fixed header is read, no extension has been walked yet.
  a_fixed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == ipv6ehw_pkg::PH_FIXED |-> state_q.nh_pos == '0 && count_q == '0)
    else $error("fixed header phase with extension state");

  // A byte that waits for the result slot stays in the input register.
  a_inq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inq_v_q && !proc |=> inq_v_q && $stable(inq_q))
    else $error("waiting input byte lost");

  // Drop and fragment results carry no protocol; a drop carries no offsets.
  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outq_v_q && outq_q.status == ipv6ehw_pkg::ST_DROP |->
      outq_q.l3_length == '0 && outq_q.l4_protocol == '0 && outq_q.next_offset == '0)
    else $error("drop result with nonzero fields");

  a_break_proto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outq_v_q && outq_q.status == ipv6ehw_pkg::ST_BREAK |-> outq_q.l4_protocol == '0)
    else $error("fragment result with protocol");

endmodule

FILE: design/ipv6ehw_step.sv
// Next-state and result logic for one packet byte of the extension header walk.
module ipv6ehw_step #(
  parameter int unsigned MAX_HEADERS = ipv6ehw_pkg::MAX_HEADERS_DEF,
  localparam int unsigned CntW = $clog2(MAX_HEADERS + 1)
) (
  input  ipv6ehw_pkg::walk_state_t state_i,
  input  logic [CntW-1:0]          count_i,
  input  ipv6ehw_pkg::in_beat_t    beat_i,
  output ipv6ehw_pkg::walk_state_t state_o,
  output logic [CntW-1:0]          count_o,
  output logic                     res_valid_o,
  output ipv6ehw_pkg::out_beat_t   res_o
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_HEADERS);

  ipv6ehw_pkg::walk_state_t cur;
  ipv6ehw_pkg::walk_state_t nxt;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_n;
  logic [CntW-1:0] w_cnt;
  logic [7:0]      w_proto;
  logic [15:0]     w_nh;
  logic            go_walk;
  logic            hit;
  logic [15:0]     pos;
  logic [15:0]     nh_f;
  logic [15:0]     nh_n;
  logic [8:0]      len_p1;
  logic [15:0]     abs_off;
  ipv6ehw_pkg::out_beat_t res;

  always_comb begin
    cur = state_i;
    cnt = count_i;
    if (beat_i.first_byte) begin
      cur.base_off  = beat_i.start_offset;
      cur.link_len  = beat_i.l2_length;
      cur.byte_pos  = '0;
      cur.nh_pos    = '0;
      cur.cur_proto = '0;
      cur.cap_nh    = '0;
      cur.phase     = ipv6ehw_pkg::PH_FIXED;
      cnt           = '0;
    end

    nxt     = cur;
    cnt_n   = cnt;
    hit     = 1'b0;
    go_walk = 1'b0;
    w_proto = cur.cur_proto;
    w_nh    = cur.nh_pos;
    w_cnt   = cnt;
    pos     = cur.byte_pos;
    nh_f    = cur.nh_pos + ipv6ehw_pkg::FRAG_LEN;
    len_p1  = {1'b0, beat_i.data_byte} + 9'd1;
    nh_n    = cur.nh_pos + {4'b0000, len_p1, 3'b000};
    abs_off = '0;
    res     = '{status: ipv6ehw_pkg::ST_DROP, l3_length: '0, l4_protocol: '0,
                next_offset: '0};

    if (cur.phase == ipv6ehw_pkg::PH_FIXED || cur.phase == ipv6ehw_pkg::PH_EXT) begin
      if (pos != ipv6ehw_pkg::POS_MAX) begin
        nxt.byte_pos = pos + 16'd1;
      end

      if (cur.phase == ipv6ehw_pkg::PH_FIXED) begin
        if (pos == ipv6ehw_pkg::NH_POS) begin
          nxt.cur_proto = beat_i.data_byte;
        end
        if (pos == ipv6ehw_pkg::FIXED_LEN - 16'd1) begin
          nxt.nh_pos = ipv6ehw_pkg::FIXED_LEN;
          w_nh       = ipv6ehw_pkg::FIXED_LEN;
          case (cur.cur_proto) inside
            ipv6ehw_pkg::P_HOPOPTS, ipv6ehw_pkg::P_ROUTING, ipv6ehw_pkg::P_FRAGMENT,
            ipv6ehw_pkg::P_ESP, ipv6ehw_pkg::P_AH, ipv6ehw_pkg::P_DSTOPTS: begin
              go_walk = 1'b1;
            end
            default: begin
              // Plain upper-layer protocol right after the fixed header.
              hit             = 1'b1;
              res.status      = ipv6ehw_pkg::ST_OK;
              res.l3_length   = ipv6ehw_pkg::FIXED_LEN;
              res.l4_protocol = cur.cur_proto;
              res.next_offset = cur.base_off + ipv6ehw_pkg::FIXED_LEN;
            end
          endcase
        end
      end else begin
        if (pos == cur.nh_pos) begin
          nxt.cap_nh = beat_i.data_byte;
        end else if ({1'b0, pos} == {1'b0, cur.nh_pos} + 17'd1) begin
          if (cur.cur_proto == ipv6ehw_pkg::P_FRAGMENT) begin
            nxt.nh_pos = nh_f;
            hit        = 1'b1;
            if (cur.cap_nh != ipv6ehw_pkg::P_HOPOPTS) begin
              abs_off         = cur.base_off + nh_f;
              res.status      = ipv6ehw_pkg::ST_BREAK;
              res.l3_length   = abs_off - cur.link_len;
              res.next_offset = abs_off;
            end
          end else begin
            nxt.nh_pos    = nh_n;
            nxt.cur_proto = cur.cap_nh;
            cnt_n         = cnt + CntW'(1);
            w_proto       = cur.cap_nh;
            w_nh          = nh_n;
            w_cnt         = cnt + CntW'(1);
            go_walk       = 1'b1;
          end
        end
      end

      if (go_walk) begin
        if (w_cnt >= CntMax) begin
          hit = 1'b1;
        end else begin
          case (w_proto) inside
            ipv6ehw_pkg::P_HOPOPTS, ipv6ehw_pkg::P_ROUTING, ipv6ehw_pkg::P_DSTOPTS,
            ipv6ehw_pkg::P_FRAGMENT: begin
              nxt.phase = ipv6ehw_pkg::PH_EXT;
            end
            ipv6ehw_pkg::P_NONE: begin
              hit = 1'b1;
            end
            default: begin
              hit             = 1'b1;
              abs_off         = cur.base_off + w_nh;
              res.status      = ipv6ehw_pkg::ST_OK;
              res.l3_length   = abs_off - cur.link_len;
              res.l4_protocol = w_proto;
              res.next_offset = abs_off;
            end
          endcase
        end
      end

      // A packet that ends before its result is decided is dropped.
      if (!hit && beat_i.last_byte) begin
        hit = 1'b1;
      end
      if (hit) begin
        nxt.phase = beat_i.last_byte ? ipv6ehw_pkg::PH_IDLE : ipv6ehw_pkg::PH_DONE;
      end
    end else if (beat_i.last_byte) begin
      nxt.phase = ipv6ehw_pkg::PH_IDLE;
    end
  end

  assign state_o     = nxt;
  assign count_o     = cnt_n;
  assign res_valid_o = hit;
  assign res_o       = res;

endmodule
